FILE: hdl/rxa_pkg.sv
`timescale 1ns / 1ps

package rxa_pkg;

   // Depth of the command queue between the front and the back.
   localparam int RXA_QUEUE_DEPTH = 2;

   // Instruction codes carried on the mode field.
   localparam logic [3:0] MODE_EXG  = 4'd8;
   localparam logic [3:0] MODE_TFR  = 4'd9;
   localparam logic [3:0] MODE_LOAD = 4'd10;

   // Register selectors with special treatment.
   localparam logic [3:0] SEL_A  = 4'd8;
   localparam logic [3:0] SEL_B  = 4'd9;
   localparam logic [3:0] SEL_CC = 4'd10;
   localparam logic [3:0] SEL_DP = 4'd11;
   localparam logic [3:0] SEL_E  = 4'd14;
   localparam logic [3:0] SEL_F  = 4'd15;

   // Slots of the wide registers that hold the byte registers.
   localparam logic [2:0] SLOT_D = 3'd0;
   localparam logic [2:0] SLOT_W = 3'd6;

   // Classes of work that the front hands to the back.
   typedef enum logic [2:0] {
      KIND_ALU,
      KIND_EXG,
      KIND_TFR,
      KIND_LOAD,
      KIND_NONE
   } kind_type;

   // ALU operations, in the order of the low mode codes.
   typedef enum logic [2:0] {
      OP_ADD,
      OP_ADC,
      OP_SUB,
      OP_SBC,
      OP_AND,
      OP_OR,
      OP_EOR,
      OP_CMP
   } alu_op_type;

   // One classified instruction.
   typedef struct packed {
      kind_type    kind;
      alu_op_type  op;
      logic        is_byte;
      logic [3:0]  first_sel;
      logic [3:0]  second_sel;
      logic [15:0] load_value;
   } cmd_type;

   // Queue head as the back sees it.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

FILE: hdl/register_exchange_and_alu.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// request   in         req_push / req_full   req_mode, req_postbyte, req_load_value
// response  out        rsp_pop / rsp_empty   rsp_first_value, rsp_second_value, rsp_flags
//
// One item per cycle is sustained while the result is free or popped; the back executes
// each command as it takes it, reading and writing the flop register file.
// An accepted item is registered in the command queue, then in the result register.
// Reset is synchronous and clears the registers, CC, DP, the command queue and the result valid flag.
// While pop is low the result holds, the back stops and the queue takes up to
// QueueDepth further items before full rises.

module register_exchange_and_alu #(
   parameter int QueueDepth = rxa_pkg::RXA_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [3:0]  req_mode,
   input  logic [7:0]  req_postbyte,
   input  logic [15:0] req_load_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_first_value,
   output logic [15:0] rsp_second_value,
   output logic [7:0]  rsp_flags
);
   import rxa_pkg::*;

   cmd_chan_type head;
   logic         take;

   // Front: classify and queue the items.
   rxa_front #(
      .DEPTH (QueueDepth)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_postbyte   (req_postbyte),
      .req_load_value (req_load_value),
      .head           (head),
      .take           (take)
   );

   // Back: execute against the register file and hold the result.
   rxa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .take             (take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_flags        (rsp_flags)
   );

endmodule

FILE: hdl/rxa_front.sv
`timescale 1ns / 1ps

module rxa_front #(
   parameter int DEPTH = rxa_pkg::RXA_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [3:0]           req_mode,
   input  logic [7:0]           req_postbyte,
   input  logic [15:0]          req_load_value,
   output rxa_pkg::cmd_chan_type head,
   input  logic                 take
);
   import rxa_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   cmd_type          decoded;
   logic             push_ok;
   logic             pop_ok;

   // Classify the incoming item by its mode and selectors.
   always_comb begin
      decoded.first_sel  = req_postbyte[7:4];
      decoded.second_sel = req_postbyte[3:0];
      decoded.load_value = req_load_value;
      decoded.op         = alu_op_type'(req_mode[2:0]);
      // Byte width only when both selectors name byte registers.
      decoded.is_byte    = req_postbyte[7] & req_postbyte[3];
      if (!req_mode[3]) begin
         decoded.kind = KIND_ALU;
      end else if (req_mode == MODE_EXG) begin
         decoded.kind = KIND_EXG;
      end else if (req_mode == MODE_TFR) begin
         decoded.kind = KIND_TFR;
      end else if (req_mode == MODE_LOAD) begin
         decoded.kind = KIND_LOAD;
      end else begin
         decoded.kind = KIND_NONE;
      end
   end

   assign req_full   = (count_ff == CntW'(DEPTH));
   assign push_ok    = req_push & ~req_full;
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign pop_ok     = head.valid & take;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Queue control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("command queue holds more items than its depth");

   a_count_up : assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("command queue count did not rise on a push");

   a_count_down : assert property (@(posedge clock) disable iff (reset)
      (pop_ok && !push_ok) |=> (count_ff == $past(count_ff) - CntW'(1)))
      else $error("command queue count did not fall on a pop");

endmodule

FILE: hdl/rxa_back.sv
`timescale 1ns / 1ps

module rxa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rxa_pkg::cmd_chan_type head,
   output logic                  take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [15:0]           rsp_first_value,
   output logic [15:0]           rsp_second_value,
   output logic [7:0]            rsp_flags
);
   import rxa_pkg::*;

   // Architectural state of the register file.
   typedef struct packed {
      logic [7:0][15:0] wide;
      logic [7:0]       cc;
      logic [7:0]       dp;
   } arch_type;

   arch_type    arch_ff, arch_in;
   arch_type    flagged;
   logic        out_valid_ff;
   logic [15:0] first_ff, second_ff;
   logic [7:0]  flags_ff;
   logic [15:0] dv, sv, t1, t2;
   logic [16:0] total;
   logic [15:0] res;
   logic        cin, n_bit, z_bit, v_bit, c_bit;
   cmd_type     cmd;

   // Transfer read: byte registers appear in both halves.
   function automatic logic [15:0] xfer_read(arch_type s, logic [3:0] sel);
      logic [15:0] r;
      r = '0;
      if (!sel[3]) begin
         r = s.wide[sel[2:0]];
      end else begin
         case (sel)
            SEL_A:   r = {2{s.wide[SLOT_D][15:8]}};
            SEL_B:   r = {2{s.wide[SLOT_D][7:0]}};
            SEL_CC:  r = {2{s.cc}};
            SEL_DP:  r = {2{s.dp}};
            SEL_E:   r = {2{s.wide[SLOT_W][15:8]}};
            SEL_F:   r = {2{s.wide[SLOT_W][7:0]}};
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   // Transfer write: byte registers take the half that matches them.
   function automatic arch_type xfer_write(arch_type s, logic [3:0] sel, logic [15:0] val);
      arch_type r;
      r = s;
      if (!sel[3]) begin
         r.wide[sel[2:0]] = val;
      end else begin
         case (sel)
            SEL_A:   r.wide[SLOT_D][15:8] = val[15:8];
            SEL_B:   r.wide[SLOT_D][7:0]  = val[7:0];
            SEL_CC:  r.cc = val[7:0];
            SEL_DP:  r.dp = val[15:8];
            SEL_E:   r.wide[SLOT_W][15:8] = val[15:8];
            SEL_F:   r.wide[SLOT_W][7:0]  = val[7:0];
            default: r = s;
         endcase
      end
      return r;
   endfunction

   // Wide read: byte registers promote to their container, others to zero.
   function automatic logic [15:0] wide_read(arch_type s, logic [3:0] sel);
      logic [15:0] r;
      r = '0;
      if (!sel[3]) begin
         r = s.wide[sel[2:0]];
      end else if (sel == SEL_A || sel == SEL_B) begin
         r = s.wide[SLOT_D];
      end else if (sel == SEL_E || sel == SEL_F) begin
         r = s.wide[SLOT_W];
      end
      return r;
   endfunction

   // Wide write: writes to CC, DP and the zero selectors are dropped.
   function automatic arch_type wide_write(arch_type s, logic [3:0] sel, logic [15:0] val);
      arch_type r;
      r = s;
      if (!sel[3]) begin
         r.wide[sel[2:0]] = val;
      end else if (sel == SEL_A || sel == SEL_B) begin
         r.wide[SLOT_D] = val;
      end else if (sel == SEL_E || sel == SEL_F) begin
         r.wide[SLOT_W] = val;
      end
      return r;
   endfunction

   function automatic logic [7:0] byte_read(arch_type s, logic [3:0] sel);
      logic [7:0] r;
      case (sel)
         SEL_A:   r = s.wide[SLOT_D][15:8];
         SEL_B:   r = s.wide[SLOT_D][7:0];
         SEL_CC:  r = s.cc;
         SEL_DP:  r = s.dp;
         SEL_E:   r = s.wide[SLOT_W][15:8];
         SEL_F:   r = s.wide[SLOT_W][7:0];
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic arch_type byte_write(arch_type s, logic [3:0] sel, logic [7:0] val);
      arch_type r;
      r = s;
      case (sel)
         SEL_A:   r.wide[SLOT_D][15:8] = val;
         SEL_B:   r.wide[SLOT_D][7:0]  = val;
         SEL_CC:  r.cc = val;
         SEL_DP:  r.dp = val;
         SEL_E:   r.wide[SLOT_W][15:8] = val;
         SEL_F:   r.wide[SLOT_W][7:0]  = val;
         default: r = s;
      endcase
      return r;
   endfunction

   assign cmd  = head.cmd;
   // The back takes a command whenever the result register is free or emptying.
   assign take = head.valid & (~out_valid_ff | rsp_pop);

   // Operand fetch and the ALU proper.
   always_comb begin
      dv  = cmd.is_byte ? {8'h00, byte_read(arch_ff, cmd.second_sel)}
                        : wide_read(arch_ff, cmd.second_sel);
      sv  = cmd.is_byte ? {8'h00, byte_read(arch_ff, cmd.first_sel)}
                        : wide_read(arch_ff, cmd.first_sel);
      cin = (cmd.op == OP_ADC || cmd.op == OP_SBC) ? arch_ff.cc[0] : 1'b0;
      if (cmd.op == OP_ADD || cmd.op == OP_ADC) begin
         total = {1'b0, dv} + {1'b0, sv} + {16'h0000, cin};
      end else begin
         total = {1'b0, dv} - {1'b0, sv} - {16'h0000, cin};
      end
      unique case (cmd.op)
         OP_AND:  res = dv & sv;
         OP_OR:   res = dv | sv;
         OP_EOR:  res = dv ^ sv;
         default: res = total[15:0];
      endcase
      // Carry or borrow out of the top bit; overflow is carry into it xor carry out.
      if (cmd.op == OP_AND || cmd.op == OP_OR || cmd.op == OP_EOR) begin
         c_bit = arch_ff.cc[0];
         v_bit = 1'b0;
      end else if (cmd.is_byte) begin
         c_bit = total[8];
         v_bit = dv[7] ^ sv[7] ^ total[7] ^ total[8];
      end else begin
         c_bit = total[16];
         v_bit = dv[15] ^ sv[15] ^ total[15] ^ total[16];
      end
      n_bit = cmd.is_byte ? res[7] : res[15];
      z_bit = cmd.is_byte ? (res[7:0] == 8'h00) : (res == 16'h0000);
      flagged    = arch_ff;
      flagged.cc = {arch_ff.cc[7:4], n_bit, z_bit, v_bit, c_bit};
   end

   // Next architectural state for the command at the head.
   always_comb begin
      t1      = xfer_read(arch_ff, cmd.first_sel);
      t2      = xfer_read(arch_ff, cmd.second_sel);
      arch_in = arch_ff;
      unique case (cmd.kind)
         KIND_ALU: begin
            if (cmd.op == OP_CMP) begin
               arch_in = flagged;
            end else if (cmd.is_byte) begin
               arch_in = byte_write(flagged, cmd.second_sel, res[7:0]);
            end else begin
               arch_in = wide_write(flagged, cmd.second_sel, res);
            end
         end
         KIND_EXG: begin
            // The second write lands last and wins on overlap.
            arch_in = xfer_write(xfer_write(arch_ff, cmd.first_sel, t2),
                                 cmd.second_sel, t1);
         end
         KIND_TFR:  arch_in = xfer_write(arch_ff, cmd.second_sel, t1);
         KIND_LOAD: arch_in = xfer_write(arch_ff, cmd.second_sel, cmd.load_value);
         default:   arch_in = arch_ff;
      endcase
   end

   // Register file, condition codes and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            arch_ff <= arch_in;
         end
         if (take) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result register, read back from the updated state.
   always_ff @(posedge clock) begin
      if (take) begin
         first_ff  <= xfer_read(arch_in, cmd.first_sel);
         second_ff <= xfer_read(arch_in, cmd.second_sel);
         flags_ff  <= arch_in.cc;
      end
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_first_value  = first_ff;
   assign rsp_second_value = second_ff;
   assign rsp_flags        = flags_ff;

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> out_valid_ff)
      else $error("waiting result was dropped without a pop");

   a_take_fills : assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("executed command left no result");

   a_take_room : assert property (@(posedge clock) disable iff (reset)
      take |-> (!out_valid_ff || rsp_pop))
      else $error("command executed over a waiting result");

endmodule
